### rtl/core/fcorr_pkg.sv
`default_nettype none
package fcorr_pkg;

  // sizes
  localparam int MAX_TAPS  = 16;
  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int CNT_W     = TAP_W + 1;
  localparam int SMP_W     = 16;
  localparam int IDX_W     = 12;
  localparam int PROD_W    = 2 * SMP_W;
  localparam int ACC_W     = PROD_W + TAP_W;
  localparam int SCL_W     = 8;
  localparam int SC_W      = ACC_W + SCL_W + 1;
  localparam int MAG_W     = SC_W - 1;
  localparam int QX_W      = MAG_W - 16;
  localparam int QS_W      = 20;
  localparam int RCP_W     = 21;
  localparam int RCP_SH    = 25;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 1'b1;
  localparam logic [CNT_W-1:0]     TAP_COUNT_RST = 5'd1;
  localparam logic [SCL_W-1:0]     SCALE_RST     = 8'd100;

  // item codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  // divide by 100 * 2^14 with rounding: add half, drop 16 bits, divide by 25
  localparam logic [MAG_W-1:0] RND_HALF  = MAG_W'(819200);
  localparam logic [RCP_W-1:0] RECIP_25  = RCP_W'(1342178);
  localparam logic [QX_W-1:0]  CLIP_POS  = QX_W'(819200);
  localparam logic [QX_W-1:0]  CLIP_NEG  = QX_W'(819225);
  localparam logic [SMP_W-1:0] SAT_POS   = 16'h7fff;
  localparam logic [SMP_W-1:0] SAT_NEG   = 16'h8000;

  typedef struct packed {
    logic                    cmd;
    logic [TAP_W-1:0]        tap_index;
    logic signed [SMP_W-1:0] value;
    logic                    block_end;
  } in_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] filtered;
    logic [IDX_W-1:0]        out_index;
    logic                    clipped;
    logic                    overrun;
    logic                    final_output;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic             tap_wr;
    logic             shift;
    logic             acc_clr;
    logic             mac;
    logic             scale;
    logic             rnd;
    logic             emit;
    logic             blk_clr;
    logic             last;
    logic [CNT_W-1:0] pos;
    logic [TAP_W-1:0] k;
  } fcorr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] taps;
    logic             out_free;
  } fcorr_stat_t;

endpackage
`default_nettype wire

### rtl/core/fir_correlation_with_tail.sv
// Streaming 1-D correlation with a flushed block tail.
// Input channel (in_valid/in_ready/in_data): a tap word (cmd set) loads one
// Q2.14 coefficient; a sample word shifts one Q8.8 sample into a 16-deep
// window and releases every output whose samples are present. A sample with
// block_end set releases all remaining outputs of the block, then clears the
// window, the output index and the overrun flag.
// Output channel (out_valid/out_ready/out_data): one registered word per output.
// Configuration: cfg_we with cfg_index 0 sets tap_count, 1 sets scale_percent;
// write only while idle.
// Sequence: a tap word is stored when accepted; a sample word is shifted in,
// then each output it releases passes a check state, the single shared
// multiply-accumulate that walks the taps one per cycle, then a scale, a
// rounding and a write state; a final check returns the sequencer to idle.
// A stalled receiver holds the output register; the sequencer waits before
// writing the next output and in_ready stays low until the item is done.
// Reset (rst_n, synchronous) clears taps, window and counters, and sets
// tap_count to 1 and scale_percent to 100.
`default_nettype none
module fir_correlation_with_tail
  import fcorr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fcorr_cmd_t  cmd;
  fcorr_stat_t stat;

  // sequencer
  fcorr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stores, arithmetic and output register
  fcorr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an output is never written over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("output written while register held");

  // the tap walk stays within the taps in use
  a_mac_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac |-> ({1'b0, cmd.k} < stat.taps))
    else $error("tap walk past tap count");

  // datapath commands never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.tap_wr, cmd.shift, cmd.acc_clr, cmd.mac, cmd.scale, cmd.rnd,
              cmd.emit, cmd.blk_clr}))
    else $error("overlapping datapath commands");

  // an item is taken only when no output is in flight in the datapath
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !(cmd.mac || cmd.scale || cmd.rnd || cmd.emit))
    else $error("item accepted during computation");

endmodule
`default_nettype wire

### rtl/core/fcorr_ctrl.sv
`default_nettype none
module fcorr_ctrl
  import fcorr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  input  fcorr_stat_t stat,
  output fcorr_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_RND   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [TAP_W-1:0] k_r, k_nxt;
  logic             bend_r, bend_nxt;
  logic             accept;
  logic             want;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // another output is due once its samples are all in, or while any remain when flushing
  assign want = bend_r ? (seen_r != '0) : (seen_r >= stat.taps);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    seen_nxt    = seen_r;
    k_nxt       = k_r;
    bend_nxt    = bend_r;
    cmd         = '0;
    cmd.pos     = CNT_W'(MAX_TAPS) - seen_r;
    cmd.k       = k_r;
    cmd.last    = bend_r && (seen_r == CNT_W'(1));
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_TAP) begin
            cmd.tap_wr = 1'b1;
          end else begin
            cmd.shift = 1'b1;
            if (seen_r != CNT_W'(MAX_TAPS)) seen_nxt = seen_r + CNT_W'(1);
            bend_nxt  = in_data.block_end;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (want) begin
          cmd.acc_clr = 1'b1;
          k_nxt       = '0;
          state_nxt   = ST_MAC;
        end else begin
          cmd.blk_clr = bend_r;
          state_nxt   = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if ({1'b0, k_r} == stat.taps - CNT_W'(1)) begin
          state_nxt = ST_SCALE;
        end else begin
          k_nxt = k_r + TAP_W'(1);
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          seen_nxt  = seen_r - CNT_W'(1);
          state_nxt = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= '0;
      k_r     <= '0;
      bend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      k_r     <= k_nxt;
      bend_r  <= bend_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/fcorr_dp.sv
`default_nettype none
module fcorr_dp
  import fcorr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_word_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  fcorr_cmd_t            cmd,
  output fcorr_stat_t           stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  logic [CNT_W-1:0]        tap_count_r;
  logic [SCL_W-1:0]        scale_r;
  logic signed [SMP_W-1:0] tap_r [MAX_TAPS];
  logic signed [SMP_W-1:0] win_r [MAX_TAPS];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [SC_W-1:0]  sc_r;
  logic                    neg_r;
  logic [QX_W-1:0]         qx_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    ovr_r;
  logic                    out_valid_r;
  out_word_t               out_r;

  logic [CNT_W-1:0]         taps;
  logic [CNT_W-1:0]         p;
  logic signed [SMP_W-1:0]  smp;
  logic signed [PROD_W-1:0] prod;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         rnd;
  logic [QS_W+RCP_W-1:0]    qmul;
  logic [SMP_W-1:0]         quot;
  logic [SMP_W-1:0]         res;
  logic                     clip;

  // effective tap count, limited to 1..MAX_TAPS
  always_comb begin
    priority if (tap_count_r == '0) begin
      taps = CNT_W'(1);
    end else if (tap_count_r > CNT_W'(MAX_TAPS)) begin
      taps = CNT_W'(MAX_TAPS);
    end else begin
      taps = tap_count_r;
    end
  end

  assign stat.taps     = taps;
  assign stat.out_free = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
      scale_r     <= SCALE_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_TAP_COUNT) tap_count_r <= cfg_data[CNT_W-1:0];
      if (cfg_index == REG_SCALE)     scale_r     <= cfg_data[SCL_W-1:0];
    end
  end

  // tap store and sample window, newest sample at the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        tap_r[i] <= '0;
        win_r[i] <= '0;
      end
    end else begin
      if (cmd.tap_wr) tap_r[in_data.tap_index] <= in_data.value;
      if (cmd.shift) begin
        for (int i = 0; i < MAX_TAPS - 1; i++) win_r[i] <= win_r[i+1];
        win_r[MAX_TAPS-1] <= in_data.value;
      end else if (cmd.blk_clr) begin
        for (int i = 0; i < MAX_TAPS; i++) win_r[i] <= '0;
      end
    end
  end

  // shared multiply-accumulate, samples past the window read as zero
  assign p    = cmd.pos + {1'b0, cmd.k};
  assign smp  = p[TAP_W] ? '0 : win_r[p[TAP_W-1:0]];
  assign prod = smp * tap_r[cmd.k];

  // magnitude plus half the divisor
  assign mag = sc_r[SC_W-1] ? MAG_W'(-sc_r) : MAG_W'(sc_r);
  assign rnd = mag + RND_HALF;

  // divide by 25 through the reciprocal, exact below the clip limit
  assign qmul = qx_r[QS_W-1:0] * RECIP_25;
  assign quot = qmul[RCP_SH +: SMP_W];

  always_comb begin
    clip = 1'b0;
    if (neg_r) begin
      if (qx_r >= CLIP_NEG) begin
        clip = 1'b1;
        res  = SAT_NEG;
      end else begin
        res = ~quot + SMP_W'(1);
      end
    end else begin
      if (qx_r >= CLIP_POS) begin
        clip = 1'b1;
        res  = SAT_POS;
      end else begin
        res = quot;
      end
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc_r <= '0;
    else if (cmd.mac) acc_r <= acc_r + ACC_W'(prod);
    if (cmd.scale) sc_r <= acc_r * $signed({1'b0, scale_r});
    if (cmd.rnd) begin
      neg_r <= sc_r[SC_W-1];
      qx_r  <= rnd[MAG_W-1:16];
    end
  end

  // output index and sticky overrun for the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ovr_r <= 1'b0;
    end else if (cmd.blk_clr) begin
      idx_r <= '0;
      ovr_r <= 1'b0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + IDX_W'(1);
      if (idx_r == '1) ovr_r <= 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.filtered     <= res;
      out_r.out_index    <= idx_r;
      out_r.clipped      <= clip;
      out_r.overrun      <= ovr_r;
      out_r.final_output <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### tb/tb_fir_correlation_with_tail.sv
`timescale 1ns / 1ps
module tb_fir_correlation_with_tail;
  import fcorr_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int BLOCK_LIMIT    = 4096;
  localparam int LONG_BLOCK_LEN = 20;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TAP_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  fir_correlation_with_tail uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow copy of the correlator state
  shortint          coef_store [MAX_TAPS] = '{default: 0};
  shortint          sample_win [MAX_TAPS] = '{default: 0};
  int               held_samples = 0;
  int               next_index   = 0;
  bit               overrun_seen = 1'b0;
  logic [CNT_W-1:0] tap_cfg      = TAP_COUNT_RST;
  logic [SCL_W-1:0] scale_cfg    = SCALE_RST;

  out_word_t pending_outputs [$];
  int        mismatch_count = 0;
  int        in_idle_pct    = 0;
  int        out_stall_pct  = 0;
  int        quiet_cycles   = 0;

  function automatic int taps_now();
    if (tap_cfg == 0) return 1;
    if (tap_cfg > MAX_TAPS) return MAX_TAPS;
    return int'(tap_cfg);
  endfunction

  // one correlation output starting at window slot pos
  function automatic out_word_t corr_output(input int pos, input int taps, input bit last);
    longint    acc;
    longint    mag;
    longint    q;
    bit        neg;
    bit        clip;
    out_word_t o;
    acc  = 0;
    clip = 1'b0;
    for (int k = 0; k < taps; k++) begin
      if (pos + k < MAX_TAPS)
        acc += longint'(sample_win[pos + k]) * longint'(coef_store[k]);
    end
    acc = acc * longint'(scale_cfg);
    neg = acc < 0;
    mag = neg ? -acc : acc;
    // divide by 100 * 2^14, ties away from zero
    q = (mag + 64'sd819200) / 64'sd1638400;
    if (neg) begin
      if (q > 32768) begin
        q    = 32768;
        clip = 1'b1;
      end
      q = -q;
    end else if (q > 32767) begin
      q    = 32767;
      clip = 1'b1;
    end
    if (next_index >= BLOCK_LIMIT) overrun_seen = 1'b1;
    o.filtered     = 16'(q);
    o.out_index    = 12'(next_index);
    o.clipped      = clip;
    o.overrun      = overrun_seen;
    o.final_output = last;
    next_index++;
    return o;
  endfunction

  // update the shadow state for an accepted word and queue its outputs
  task automatic corr_predict(input in_word_t w);
    int taps;
    taps = taps_now();
    if (w.cmd == CMD_TAP) begin
      coef_store[w.tap_index] = w.value;
      return;
    end
    for (int j = 0; j < MAX_TAPS - 1; j++) sample_win[j] = sample_win[j + 1];
    sample_win[MAX_TAPS - 1] = w.value;
    if (held_samples < MAX_TAPS) held_samples++;
    if (w.block_end) begin
      // flush the tail, samples past the end read as zero
      while (held_samples > 0) begin
        pending_outputs.push_back(corr_output(MAX_TAPS - held_samples, taps,
                                              held_samples == 1));
        held_samples--;
      end
      sample_win   = '{default: 0};
      next_index   = 0;
      overrun_seen = 1'b0;
    end else begin
      while (held_samples >= taps) begin
        pending_outputs.push_back(corr_output(MAX_TAPS - held_samples, taps, 1'b0));
        held_samples--;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input out_word_t want,
                                 input out_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected filtered=%0d index=%0d clip=%0b ovr=%0b last=%0b",
               $realtime, what, want.filtered, want.out_index, want.clipped,
               want.overrun, want.final_output);
      $display("%0t %s: got filtered=%0d index=%0d clip=%0b ovr=%0b last=%0b",
               $realtime, what, got.filtered, got.out_index, got.clipped,
               got.overrun, got.final_output);
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (pending_outputs.size() == 0) begin
      report_mismatch("unexpected word", '0, got);
      return;
    end
    want = pending_outputs.pop_front();
    if (got.filtered !== want.filtered || got.out_index !== want.out_index ||
        got.clipped !== want.clipped || got.overrun !== want.overrun ||
        got.final_output !== want.final_output)
      report_mismatch("wrong word", want, got);
  endtask

  // receiver side: random stalls and result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_word(out_data);
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // sender side: optional gap, then hold the word until accepted
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    corr_predict(w);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_outputs.size() != 0);
  endtask

  // idle means all outputs in and the last word fully retired
  task automatic settle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input int taps, input int gain);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TAP_COUNT;
    cfg_data  <= CFG_DATA_W'(taps);
    @(posedge clk);
    cfg_index <= REG_SCALE;
    cfg_data  <= CFG_DATA_W'(gain);
    @(posedge clk);
    cfg_we    <= 1'b0;
    tap_cfg   = CNT_W'(taps);
    scale_cfg = SCL_W'(gain);
    @(posedge clk);
  endtask

  function automatic in_word_t make_tap(input logic [TAP_W-1:0] idx, input logic [15:0] val,
                                        input logic be);
    in_word_t w;
    w.cmd       = CMD_TAP;
    w.tap_index = idx;
    w.value     = val;
    w.block_end = be;
    return w;
  endfunction

  function automatic in_word_t make_sample(input logic [15:0] val, input logic be);
    in_word_t w;
    w.cmd       = CMD_SAMPLE;
    w.tap_index = TAP_W'($urandom);
    w.value     = val;
    w.block_end = be;
    return w;
  endfunction

  // mix of rail values, small values and the full range
  function automatic logic [15:0] rand_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h7fff;
    if (pick == 1) return 16'h8000;
    if (pick < 5) return 16'($signed($urandom_range(0, 1024)) - 512);
    return 16'($urandom);
  endfunction

  function automatic int rand_taps();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(17, 31);
    return $urandom_range(1, MAX_TAPS);
  endfunction

  function automatic int rand_scale();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  task automatic test_directed();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    // tap word carrying block_end: stored, nothing released
    send_word(make_tap(4'd0, 16'sd16384, 1'b1));
    send_word(make_sample(16'h7fff, 1'b0));
    send_word(make_sample(16'h8000, 1'b0));
    send_word(make_sample(16'sd256, 1'b1));
    // block of a single sample
    send_word(make_sample(-16'sd77, 1'b1));
    // zero tap count acts as one tap; full gain drives both rails
    write_regs(0, 255);
    send_word(make_tap(4'd0, 16'h8000, 1'b0));
    send_word(make_sample(16'h8000, 1'b0));
    send_word(make_sample(16'h7fff, 1'b1));
    // tap count past the store with zero gain
    write_regs(17, 0);
    send_word(make_tap(4'd15, 16'h7fff, 1'b0));
    send_word(make_sample(16'h7fff, 1'b0));
    send_word(make_sample(16'h1234, 1'b1));
    // widest count, short block flushed with zero padding
    write_regs(31, 255);
    send_word(make_tap(4'd7, 16'hffff, 1'b1));
    send_word(make_sample(16'h4000, 1'b0));
    send_word(make_sample(16'h8000, 1'b0));
    send_word(make_sample(16'h7fff, 1'b1));
    // tap count shortened mid-block releases the backlog at once
    write_regs(4, 100);
    send_word(make_tap(4'd1, 16'sd8192, 1'b0));
    send_word(make_tap(4'd2, -16'sd4096, 1'b0));
    send_word(make_tap(4'd3, 16'sd12345, 1'b0));
    send_word(make_sample(16'sd1000, 1'b0));
    send_word(make_sample(-16'sd2000, 1'b0));
    write_regs(1, 100);
    send_word(make_sample(16'sd3000, 1'b0));
    send_word(make_sample(16'sd5, 1'b1));
  endtask

  // block longer than the window, back to back, flushed at the end
  task automatic test_long_block();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_regs(2, 100);
    send_word(make_tap(4'd1, 16'($urandom), 1'b0));
    for (int n = 0; n < LONG_BLOCK_LEN; n++)
      send_word(make_sample(rand_value(), n == LONG_BLOCK_LEN - 1));
  endtask

  // blocks of random length and content, stray tap loads, setting changes
  task automatic test_random_phase(input int idle_in, input int stall_out, input int n_items,
                                   input int first_taps, input int first_scale);
    int sent;
    int blk_len;
    bit paused;
    in_idle_pct   = idle_in;
    out_stall_pct = stall_out;
    sent          = 0;
    paused        = 1'b0;
    write_regs(first_taps, first_scale);
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) write_regs(rand_taps(), rand_scale());
      blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int pos = 0; pos < blk_len; pos++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_word(make_tap(TAP_W'($urandom), rand_value(), 1'($urandom)));
          sent++;
        end
        if (pos > 0 && $urandom_range(0, 24) == 0) write_regs(rand_taps(), rand_scale());
        send_word(make_sample(rand_value(), pos == blk_len - 1));
        sent++;
      end
      if (!paused && sent >= n_items / 2) begin
        pause_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_block();
    test_random_phase(0, 0, 85, 16, 255);
    test_random_phase(55, 0, 85, 0, 0);
    test_random_phase(0, 55, 85, 31, 100);
    test_random_phase(34, 34, 85, 7, 200);
    settle();
    if (mismatch_count == 0 && pending_outputs.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/fcorr_pkg.sv
rtl/core/fcorr_ctrl.sv
rtl/core/fcorr_dp.sv
rtl/core/fir_correlation_with_tail.sv
tb/tb_fir_correlation_with_tail.sv
